FILE: sv/terr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package terr_pkg;

   // Request codes carried in the input tuser.
   typedef enum logic [3:0] {
      REQ_TICK         = 4'd0,
      REQ_RECORD       = 4'd1,
      REQ_START_RECORD = 4'd2,
      REQ_STOP_RECORD  = 4'd3,
      REQ_START_REPLAY = 4'd4,
      REQ_STOP_REPLAY  = 4'd5,
      REQ_PAUSE        = 4'd6,
      REQ_SEEK         = 4'd7,
      REQ_CLEAR        = 4'd8
   } req_code_type;

   // Result kinds carried in the output tuser.
   typedef enum logic [1:0] {
      KIND_STATUS = 2'd0,
      KIND_EVENT  = 2'd1,
      KIND_REJECT = 2'd2
   } result_kind_type;

   // Recorder modes as reported in each result.
   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_RECORD = 2'd1,
      MODE_REPLAY = 2'd2
   } mode_type;

   localparam int REQ_DATA_W    = 144;
   localparam int RSP_DATA_W    = 184;
   localparam int EVENT_COUNT_W = 7;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   // Register index, taken from the word address bit of paddr.
   localparam logic REG_PLAYBACK_SPEED = 1'b0;

   localparam logic [15:0] SPEED_FLOOR = 16'd3;
   localparam logic [15:0] SPEED_RESET = 16'd256;

   // One stored event.
   typedef struct packed {
      logic [31:0] stamp;
      logic [7:0]  code;
      logic [31:0] value;
      logic [31:0] x;
      logic [31:0] y;
   } event_rec_type;

   // Input tdata layout, last field in the lowest bits.
   typedef struct packed {
      logic [6:0]  pad;
      logic [31:0] in_y;
      logic [31:0] in_x;
      logic [31:0] in_value;
      logic [7:0]  in_type;
      logic [31:0] time_value;
      logic        flag;
   } req_data_type;

   // Output tdata layout, last field in the lowest bits.
   typedef struct packed {
      logic [4:0]               pad;
      logic                     replay_ended;
      logic [31:0]              position;
      logic [EVENT_COUNT_W-1:0] event_count;
      logic                     paused_now;
      logic [1:0]               mode;
      logic [31:0]              out_time;
      logic [31:0]              out_y;
      logic [31:0]              out_x;
      logic [31:0]              out_value;
      logic [7:0]               out_type;
   } rsp_data_type;

endpackage

`default_nettype wire

FILE: sv/terr_event_store.sv
`timescale 1ns / 1ps
`default_nettype none

module terr_event_store
   import terr_pkg::*;
#(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire event_rec_type     wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output event_rec_type          rd_data
);

   event_rec_type mem [DEPTH];
   event_rec_type rd_data_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/timestamped_event_record_replay.sv
`timescale 1ns / 1ps
`default_nettype none
// Status and reject results are loaded in ST_STATUS, after ST_EXEC, once the output register
// is free; the next item is accepted in the cycle after the last result of an item is loaded.
// A replay tick runs ST_EXEC, ST_ADV, ST_SCAN_RD and ST_SCAN_CMP per stored event compared,
// ST_SCAN_DONE, then ST_EMIT_RD and ST_EMIT_WAIT per replayed item (ST_STATUS for a status
// item); a seek runs ST_EXEC, then ST_SCAN_RD and ST_SCAN_CMP per stored event.
// Reset (synchronous, active high) clears all control state; the event store is not cleared.

module timestamped_event_record_replay
   import terr_pkg::*;
#(
   parameter int EVENT_DEPTH = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Input item channel.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // tdata: flag, time_value, in_type, in_value, in_x, in_y, zero pad (LSB first)
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: req_type
   input  wire logic [3:0]            req_tuser,
   // Result item channel.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // tdata: out_type, out_value, out_x, out_y, out_time, mode, paused_now,
   //        event_count, position, replay_ended, zero pad (LSB first)
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // tuser: result_kind
   output logic [1:0]                 rsp_tuser,
   output logic                       rsp_tlast,
   // Configuration port.
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   localparam int CNT_W  = $clog2(EVENT_DEPTH + 1);
   localparam int ADDR_W = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_EXEC      = 9'b000000010,
      ST_STATUS    = 9'b000000100,
      ST_ADV       = 9'b000001000,
      ST_SCAN_RD   = 9'b000010000,
      ST_SCAN_CMP  = 9'b000100000,
      ST_SCAN_DONE = 9'b001000000,
      ST_EMIT_RD   = 9'b010000000,
      ST_EMIT_WAIT = 9'b100000000
   } state_type;

   state_type       state_ff, state_in;
   mode_type        mode_ff, mode_in;
   logic            paused_ff, paused_in;
   logic            loop_ff, loop_in;
   logic [31:0]     clock_ff, clock_in;
   logic [31:0]     frame_ff, frame_in;
   logic [31:0]     pos_ff, pos_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] end_ff, end_in;
   logic            seek_ff, seek_in;
   logic            ended_ff, ended_in;
   logic [47:0]     prod_ff, prod_in;
   result_kind_type kind_ff, kind_in;
   logic [15:0]     speed_ff;

   req_code_type    req_code_ff;
   req_data_type    req_data_ff;

   logic            rsp_valid_ff;
   logic            rsp_last_ff;
   result_kind_type rsp_kind_ff;
   rsp_data_type    rsp_data_ff;

   logic            out_free;
   logic            load_status;
   logic            load_event;
   logic            last_event;
   logic            wr_en;
   event_rec_type   wr_data;
   event_rec_type   rd_data;
   logic [32:0]     clock_sum;
   logic [40:0]     pos_sum;
   logic            hit;
   logic            csr_wr;

   // Event store with one write and one registered read port.
   terr_event_store #(
      .DEPTH  (EVENT_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (ptr_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign wr_data.stamp = clock_ff;
   assign wr_data.code  = req_data_ff.in_type;
   assign wr_data.value = req_data_ff.in_value;
   assign wr_data.x     = req_data_ff.in_x;
   assign wr_data.y     = req_data_ff.in_y;

   // Configuration port: only the speed register, raised to its floor on write.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_PLAYBACK_SPEED) ? {16'd0, speed_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= SPEED_RESET;
      end else if (csr_wr && csr_paddr[2] == REG_PLAYBACK_SPEED) begin
         speed_ff <= (csr_pwdata[15:0] < SPEED_FLOOR) ? SPEED_FLOOR : csr_pwdata[15:0];
      end
   end

   // Handshake helpers and the adders behind the saturating sums.
   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign clock_sum  = {1'b0, clock_ff} + {1'b0, req_data_ff.time_value};
   assign pos_sum    = {9'd0, pos_ff} + {1'b0, prod_ff[47:8]};
   assign hit        = (rd_data.stamp <= pos_ff);

   // Input item capture.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_code_ff <= req_code_type'(req_tuser);
         req_data_ff <= req_data_type'(req_tdata);
      end
   end

   // Sequencer next-state logic.
   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      paused_in   = paused_ff;
      loop_in     = loop_ff;
      clock_in    = clock_ff;
      frame_in    = frame_ff;
      pos_in      = pos_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      end_in      = end_ff;
      seek_in     = seek_ff;
      ended_in    = ended_ff;
      prod_in     = prod_ff;
      kind_in     = kind_ff;
      wr_en       = 1'b0;
      load_status = 1'b0;
      load_event  = 1'b0;
      last_event  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end

         // Decode the item and apply the requests that need no scan of the store.
         ST_EXEC: begin
            ended_in = 1'b0;
            kind_in  = KIND_STATUS;
            seek_in  = 1'b0;
            state_in = ST_STATUS;
            case (req_code_ff)
               REQ_TICK: begin
                  if (mode_ff == MODE_RECORD) begin
                     clock_in = clock_sum[32] ? '1 : clock_sum[31:0];
                     frame_in = frame_ff + 32'd1;
                  end else if (mode_ff == MODE_REPLAY && !paused_ff) begin
                     prod_in  = req_data_ff.time_value * speed_ff;
                     state_in = ST_ADV;
                  end
               end
               REQ_RECORD: begin
                  if (mode_ff == MODE_RECORD) begin
                     if (count_ff >= CNT_W'(EVENT_DEPTH)) begin
                        kind_in = KIND_REJECT;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
               end
               REQ_START_RECORD: begin
                  mode_in  = MODE_RECORD;
                  clock_in = '0;
                  frame_in = '0;
                  count_in = '0;
               end
               REQ_STOP_RECORD: begin
                  if (mode_ff == MODE_RECORD) begin
                     mode_in = MODE_IDLE;
                  end
               end
               REQ_START_REPLAY: begin
                  mode_in   = MODE_REPLAY;
                  pos_in    = '0;
                  idx_in    = '0;
                  loop_in   = req_data_ff.flag;
                  paused_in = 1'b0;
               end
               REQ_STOP_REPLAY: begin
                  mode_in = MODE_IDLE;
               end
               REQ_PAUSE: begin
                  paused_in = req_data_ff.flag;
               end
               REQ_SEEK: begin
                  pos_in   = req_data_ff.time_value;
                  idx_in   = '0;
                  ptr_in   = '0;
                  seek_in  = 1'b1;
                  state_in = ST_SCAN_RD;
               end
               REQ_CLEAR: begin
                  count_in = '0;
                  pos_in   = '0;
                  idx_in   = '0;
               end
               default: begin
               end
            endcase
         end

         ST_STATUS: begin
            if (out_free) begin
               load_status = 1'b1;
               state_in    = ST_IDLE;
            end
         end

         // Advance the play position by the registered product.
         ST_ADV: begin
            pos_in   = (|pos_sum[40:32]) ? '1 : pos_sum[31:0];
            ptr_in   = idx_ff;
            state_in = ST_SCAN_RD;
         end

         // Read address is the pointer; the registered read data is back in ST_SCAN_CMP.
         ST_SCAN_RD: begin
            if (ptr_ff < count_ff) begin
               state_in = ST_SCAN_CMP;
            end else if (seek_ff) begin
               state_in = ST_STATUS;
            end else begin
               state_in = ST_SCAN_DONE;
            end
         end

         ST_SCAN_CMP: begin
            if (seek_ff) begin
               if (hit) begin
                  idx_in = idx_ff + CNT_W'(1);
               end
               ptr_in   = ptr_ff + CNT_W'(1);
               state_in = ST_SCAN_RD;
            end else if (hit) begin
               ptr_in   = ptr_ff + CNT_W'(1);
               state_in = ST_SCAN_RD;
            end else begin
               state_in = ST_SCAN_DONE;
            end
         end

         // The scan found the end of the due events; settle the final state
         // before the first result goes out, then rewind to emit them.
         ST_SCAN_DONE: begin
            end_in = ptr_ff;
            ptr_in = idx_ff;
            idx_in = ptr_ff;
            if (ptr_ff >= count_ff) begin
               if (loop_ff) begin
                  pos_in = '0;
                  idx_in = '0;
               end else begin
                  mode_in  = MODE_IDLE;
                  ended_in = 1'b1;
               end
            end
            state_in = (ptr_ff == idx_ff) ? ST_STATUS : ST_EMIT_RD;
         end

         ST_EMIT_RD: begin
            state_in = ST_EMIT_WAIT;
         end

         ST_EMIT_WAIT: begin
            if (out_free) begin
               load_event = 1'b1;
               last_event = (ptr_ff + CNT_W'(1) == end_ff);
               ptr_in     = ptr_ff + CNT_W'(1);
               state_in   = last_event ? ST_IDLE : ST_EMIT_RD;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         mode_ff   <= MODE_IDLE;
         paused_ff <= 1'b0;
         loop_ff   <= 1'b0;
         clock_ff  <= '0;
         frame_ff  <= '0;
         pos_ff    <= '0;
         idx_ff    <= '0;
         count_ff  <= '0;
         ptr_ff    <= '0;
         end_ff    <= '0;
         seek_ff   <= 1'b0;
         ended_ff  <= 1'b0;
         kind_ff   <= KIND_STATUS;
      end else begin
         state_ff  <= state_in;
         mode_ff   <= mode_in;
         paused_ff <= paused_in;
         loop_ff   <= loop_in;
         clock_ff  <= clock_in;
         frame_ff  <= frame_in;
         pos_ff    <= pos_in;
         idx_ff    <= idx_in;
         count_ff  <= count_in;
         ptr_ff    <= ptr_in;
         end_ff    <= end_in;
         seek_ff   <= seek_in;
         ended_ff  <= ended_in;
         kind_ff   <= kind_in;
      end
   end

   // Product register between the multiplier and the position adder.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Output register: holds one result item until the sink takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_status || load_event) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_status || load_event) begin
         rsp_last_ff              <= load_status ? 1'b1 : last_event;
         rsp_kind_ff              <= load_status ? kind_ff : KIND_EVENT;
         rsp_data_ff.pad          <= '0;
         rsp_data_ff.replay_ended <= ended_ff;
         rsp_data_ff.position     <= (mode_ff == MODE_REPLAY) ? pos_ff : clock_ff;
         rsp_data_ff.event_count  <= EVENT_COUNT_W'(count_ff);
         rsp_data_ff.paused_now   <= paused_ff;
         rsp_data_ff.mode         <= mode_ff;
         rsp_data_ff.out_time     <= load_event ? rd_data.stamp : '0;
         rsp_data_ff.out_y        <= load_event ? rd_data.y : '0;
         rsp_data_ff.out_x        <= load_event ? rd_data.x : '0;
         rsp_data_ff.out_value    <= load_event ? rd_data.value : '0;
         rsp_data_ff.out_type     <= load_event ? rd_data.code : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
